FILE: hdl/iol_pkg.sv
// Shared types and codes for the indexed ordered list core.
// Has no dependencies. The top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

   // Field widths on the stream ports.
   localparam int MODE_W      = 4;
   localparam int POS_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VALUE_W - COUNT_OUT_W;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd1;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_READ       = 4'd6;
   localparam logic [MODE_W-1:0] MODE_WRITE      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd8;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_READ,
      S_READ_WAIT,
      S_DONE
   } state_type;

   // Kind of list edit carried out by the shift sequencer.
   typedef enum logic [1:0] {
      KIND_OPEN,
      KIND_CLOSE,
      KIND_WRITE
   } kind_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      kind_type            kind;
      state_type           next;
   } decode_type;

endpackage

`default_nettype wire

FILE: hdl/iol_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies; width and depth come from its parameters.
`timescale 1ns / 1ps
`default_nettype none

module iol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/indexed_ordered_list_core.sv
// Indexed ordered list: push/pop at either end, insert/remove/read/write at an index, clear.
// After an accepted request beat, clears and ignored or refused requests go straight to S_DONE,
// reads pass through S_READ and S_READ_WAIT, and the other edits run S_SHIFT_RD and S_SHIFT_WR
// for each entry moved, then a last S_SHIFT_RD (none moved for back pushes, back pops, writes).
// One request at a time: the next beat is taken once the result is loaded; a stalled result waits.
// Synchronous active-high reset empties the list, not the RAM. Needs iol_pkg and iol_ram.
`timescale 1ns / 1ps
`default_nettype none

module indexed_ordered_list_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // req_tdata from bit 0 up: position[4:0], value[36:5], zero padding
   input  wire logic [iol_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser from bit 0 up: mode[3:0]
   input  wire logic [iol_pkg::MODE_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rsp_tdata from bit 0 up: read_value[31:0], entry_count[36:32], zero padding
   output logic      [iol_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser from bit 0 up: status[1:0]
   output logic      [iol_pkg::STATUS_W-1:0]    rsp_tuser
);

   import iol_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request fields.
   logic [MODE_W-1:0]     mode;
   logic [POS_W-1:0]      position;
   logic [VALUE_W-1:0]    value;
   logic [63:0]           value_wide;
   logic [DATA_WIDTH-1:0] req_word;

   assign mode       = req_tuser;
   assign position   = req_tdata[POS_W-1:0];
   assign value      = req_tdata[POS_W+VALUE_W-1:POS_W];
   assign value_wide = 64'(value);
   assign req_word   = value_wide[DATA_WIDTH-1:0];

   // Control and datapath registers.
   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]     stop_ff, stop_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [VALUE_W-1:0]    rd_ff, rd_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_read_ff, rsp_read_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // RAM port signals.
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [63:0]           ram_rdata_wide;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  at_stop;
   logic [ADDR_W-1:0]     nb_idx;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [ADDR_W-1:0]     pos_a;
   logic [ADDR_W-1:0]     cnt_a;
   logic                  list_full;
   logic                  list_empty;
   logic [15:0]           count_wide;
   decode_type            dec;
   logic [ADDR_W-1:0]     dec_idx;
   logic [ADDR_W-1:0]     dec_stop;

   assign req_accept     = req_tvalid & req_tready;
   assign ram_rdata_wide = 64'(ram_rdata);
   assign pos_ext        = CMP_W'(position);
   assign cnt_ext        = CMP_W'(count_ff);
   assign pos_a          = ADDR_W'(pos_ext);
   assign cnt_a          = ADDR_W'(count_ff);
   assign list_full      = (count_ff == CNT_W'(DEPTH));
   assign list_empty     = (count_ff == '0);
   assign at_stop        = (idx_ff == stop_ff);

   // Shared index unit: the neighbor that moves into the current slot.
   assign nb_idx = (kind_ff == KIND_OPEN) ? idx_ff - ADDR_W'(1) : idx_ff + ADDR_W'(1);

   // Request decode: status, kind of edit and the index range to sweep.
   always_comb begin
      dec.status = ST_DONE;
      dec.kind   = KIND_WRITE;
      dec.next   = S_DONE;
      dec_idx    = pos_a;
      dec_stop   = pos_a;
      case (mode)
         MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
            if (list_full) begin
               dec.status = ST_FULL;
            end else begin
               dec.kind = KIND_OPEN;
               dec.next = S_SHIFT_RD;
               dec_idx  = cnt_a;
               dec_stop = (mode == MODE_PUSH_BACK) ? cnt_a : '0;
            end
         end
         MODE_POP_BACK, MODE_POP_FRONT: begin
            if (list_empty) begin
               dec.status = ST_IGNORED;
            end else begin
               dec.kind = KIND_CLOSE;
               dec.next = S_SHIFT_RD;
               dec_idx  = (mode == MODE_POP_BACK) ? cnt_a - ADDR_W'(1) : '0;
               dec_stop = cnt_a - ADDR_W'(1);
            end
         end
         MODE_INSERT: begin
            if (pos_ext > cnt_ext) begin
               dec.status = ST_IGNORED;
            end else if (list_full) begin
               dec.status = ST_FULL;
            end else begin
               dec.kind = KIND_OPEN;
               dec.next = S_SHIFT_RD;
               dec_idx  = cnt_a;
               dec_stop = pos_a;
            end
         end
         MODE_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               dec.status = ST_IGNORED;
            end else begin
               dec.kind = KIND_CLOSE;
               dec.next = S_SHIFT_RD;
               dec_stop = cnt_a - ADDR_W'(1);
            end
         end
         MODE_READ: begin
            if (pos_ext >= cnt_ext) begin
               dec.status = ST_IGNORED;
            end else begin
               dec.next = S_READ;
            end
         end
         MODE_WRITE: begin
            if (pos_ext >= cnt_ext) begin
               dec.status = ST_IGNORED;
            end else begin
               dec.next = S_SHIFT_RD;
            end
         end
         MODE_CLEAR: begin
            dec.status = ST_DONE;
         end
         default: begin
            dec.status = ST_IGNORED;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = dec.next;
            end
         end
         S_SHIFT_RD: begin
            state_in = at_stop ? S_DONE : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_READ: begin
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State outputs: handshake and RAM control.
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff;
      ram_wdata  = word_ff;
      ram_raddr  = nb_idx;
      case (state_ff)
         S_IDLE: begin
            req_tready = ~reset;
         end
         S_SHIFT_RD: begin
            // The last step places the new word; a close only drops the count.
            ram_we = at_stop & (kind_ff != KIND_CLOSE);
         end
         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
         end
         S_READ: begin
            ram_raddr = idx_ff;
         end
         S_READ_WAIT: begin
            ram_raddr = idx_ff;
         end
         S_DONE: begin
            rsp_load = ~rsp_valid_ff | rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      kind_in   = kind_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      stop_in   = stop_ff;
      word_in   = word_ff;
      rd_in     = rd_ff;
      status_in = status_ff;

      if (req_accept) begin
         kind_in   = dec.kind;
         idx_in    = dec_idx;
         stop_in   = dec_stop;
         word_in   = req_word;
         rd_in     = '0;
         status_in = dec.status;
         if (mode == MODE_CLEAR) begin
            count_in = '0;
         end
      end

      if (state_ff == S_SHIFT_RD && at_stop) begin
         if (kind_ff == KIND_OPEN) begin
            count_in = count_ff + CNT_W'(1);
         end else if (kind_ff == KIND_CLOSE) begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      if (state_ff == S_SHIFT_WR) begin
         idx_in = nb_idx;
      end

      if (state_ff == S_READ_WAIT) begin
         rd_in = ram_rdata_wide[VALUE_W-1:0];
      end
   end

   // Result register: holds a finished beat while the next request is taken.
   assign count_wide = 16'(count_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_read_in   = rd_ff;
         rsp_count_in  = count_wide[COUNT_OUT_W-1:0];
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      stop_ff       <= stop_in;
      word_ff       <= word_in;
      rd_ff         <= rd_in;
      status_ff     <= status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   iol_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_read_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The count never runs past the capacity of the list.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count exceeds depth");

   // The count moves by one step at a time, or drops to zero on a clear.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(count_ff) |->
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)) ||
         (count_ff == '0))
      else $error("list count jumped");

   // A beat with a failed status carries zero read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_DONE) |-> (rsp_read_ff == '0))
      else $error("read data on a failed request");

   // RAM writes stay inside the list storage.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CNT_W'(ram_waddr) < CNT_W'(DEPTH)))
      else $error("entry write outside storage");

endmodule

`default_nettype wire
